@@ rtl/cpnd_pkg.sv @@
package cpnd_pkg;

  localparam int NumberWidth = 32;
  localparam int WideWidth   = NumberWidth + 5;
  localparam int StepWidth   = 32;

  localparam logic [7:0] ChrA     = 8'h41;
  localparam logic [7:0] ChrT     = 8'h54;
  localparam logic [7:0] ChrY     = 8'h59;
  localparam logic [7:0] ChrZ     = 8'h5A;
  localparam logic [7:0] ChrQuest = 8'h3F;

  typedef enum logic [3:0] {
    K_NUMBER         = 4'd0,
    K_ZERO           = 4'd1,
    K_UNKNOWN        = 4'd2,
    K_END_OK         = 4'd3,
    K_END_INCOMPLETE = 4'd4,
    K_BAD_CHAR       = 4'd5,
    K_OVERFLOW       = 4'd6,
    K_STRAY_Z        = 4'd7,
    K_UNFINISHED     = 4'd8,
    K_EMPTY          = 4'd9
  } kind_t;

  typedef struct packed {
    logic [NumberWidth-1:0] partial_number;
    logic                   just_got_number;
    logic                   error_latched;
    logic                   saw_letter;
    logic                   saw_unknown;
  } dec_state_t;

  typedef struct packed {
    logic                 has_result;
    kind_t                kind;
    logic [StepWidth-1:0] step_value;
  } dec_result_t;

endpackage

@@ rtl/cpnd_step.sv @@
module cpnd_step (
  input  cpnd_pkg::dec_state_t  state,
  input  logic [7:0]            letter,
  input  logic                  proof_end,
  output cpnd_pkg::dec_state_t  state_next,
  output cpnd_pkg::dec_result_t result
);

  localparam int NW = cpnd_pkg::NumberWidth;
  localparam int WW = cpnd_pkg::WideWidth;

  logic [WW-1:0]              ext;
  logic [7:0]                 diff20;
  logic [7:0]                 diff5;
  logic [WW-1:0]              sum20;
  logic [WW-1:0]              sum5;
  logic                       ovf20;
  logic                       ovf5;
  logic [NW+31:0]             value_ext;
  logic                       is_quest;
  logic                       is_upper;

  assign ext      = {5'b0, state.partial_number};
  assign diff20   = letter - (cpnd_pkg::ChrA - 8'd1);
  assign diff5    = letter - cpnd_pkg::ChrT;
  assign sum20    = (ext << 4) + (ext << 2) + {{(WW-5){1'b0}}, diff20[4:0]};
  assign sum5     = (ext << 2) + ext + {{(WW-5){1'b0}}, diff5[4:0]};
  assign ovf20    = |sum20[WW-1:NW];
  assign ovf5     = |sum5[WW-1:NW];
  assign value_ext = {32'b0, sum20[NW-1:0]};
  assign is_quest = letter == cpnd_pkg::ChrQuest;
  assign is_upper = (letter >= cpnd_pkg::ChrA) && (letter <= cpnd_pkg::ChrZ);

  always_comb begin
    state_next        = state;
    result.has_result = 1'b0;
    result.kind       = cpnd_pkg::K_NUMBER;
    result.step_value = '0;
    if (proof_end) begin
      state_next = '0;
      if (!state.error_latched) begin
        result.has_result = 1'b1;
        if (state.partial_number != '0) begin
          result.kind = cpnd_pkg::K_UNFINISHED;
        end else if (!state.saw_letter) begin
          result.kind = cpnd_pkg::K_EMPTY;
        end else if (state.saw_unknown) begin
          result.kind = cpnd_pkg::K_END_INCOMPLETE;
        end else begin
          result.kind = cpnd_pkg::K_END_OK;
        end
      end
    end else if (!state.error_latched) begin
      result.has_result = 1'b1;
      if (is_quest) begin
        state_next.saw_letter      = 1'b1;
        state_next.saw_unknown     = 1'b1;
        state_next.just_got_number = 1'b0;
        if (state.partial_number != '0) begin
          state_next.error_latched = 1'b1;
          result.kind              = cpnd_pkg::K_UNFINISHED;
        end else begin
          result.kind = cpnd_pkg::K_UNKNOWN;
        end
      end else if (!is_upper) begin
        state_next.error_latched = 1'b1;
        result.kind              = cpnd_pkg::K_BAD_CHAR;
      end else if (letter <= cpnd_pkg::ChrT) begin
        state_next.saw_letter = 1'b1;
        if (ovf20) begin
          state_next.error_latched = 1'b1;
          result.kind              = cpnd_pkg::K_OVERFLOW;
        end else begin
          state_next.partial_number  = '0;
          state_next.just_got_number = 1'b1;
          result.kind                = cpnd_pkg::K_NUMBER;
          result.step_value          = value_ext[31:0];
        end
      end else if (letter <= cpnd_pkg::ChrY) begin
        state_next.saw_letter = 1'b1;
        if (ovf5) begin
          state_next.error_latched = 1'b1;
          result.kind              = cpnd_pkg::K_OVERFLOW;
        end else begin
          state_next.partial_number  = sum5[NW-1:0];
          state_next.just_got_number = 1'b0;
          result.has_result          = 1'b0;
        end
      end else begin
        state_next.saw_letter = 1'b1;
        if (!state.just_got_number) begin
          state_next.error_latched = 1'b1;
          result.kind              = cpnd_pkg::K_STRAY_Z;
        end else begin
          state_next.just_got_number = 1'b0;
          result.kind                = cpnd_pkg::K_ZERO;
        end
      end
    end
  end

endmodule

@@ rtl/compressed_proof_number_decoder.sv @@
// Decodes a compressed proof letter stream, one letter per item on the slave side, into
// step numbers, zero marks, unknown-step marks, end status and error codes on the master
// side. The item with tlast high closes the proof, reports its status unless an error
// came first, and clears all state; after an error, letters give no item until that
// closing item. The block takes one item per cycle while the master side does not stall:
// each item is registered in s1, decoded by one multiply-by-constant add and overflow
// check against the running number, and its result is then registered in the output
// register. Items with no result (high digits, letters after an error) still pass s1.
module compressed_proof_number_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // letter [7:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // step_value [31:0]
  output logic [3:0]  m_tuser    // kind [3:0]
);

  logic                  s1_valid;
  logic [7:0]            s1_letter;
  logic                  s1_end;
  logic                  s1_go;
  logic                  out_free;
  cpnd_pkg::dec_state_t  state;
  cpnd_pkg::dec_state_t  state_next;
  cpnd_pkg::dec_result_t result;

  cpnd_step u_step (
    .state      (state),
    .letter     (s1_letter),
    .proof_end  (s1_end),
    .state_next (state_next),
    .result     (result)
  );

  assign out_free = !m_tvalid || m_tready;
  assign s1_go    = s1_valid && out_free;
  assign s_tready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
      state    <= '0;
    end else begin
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (out_free) begin
        m_tvalid <= s1_go && result.has_result;
      end
      if (s1_go) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_letter <= s_tdata;
      s1_end    <= s_tlast;
    end
    if (s1_go && result.has_result) begin
      m_tdata <= result.step_value;
      m_tuser <= result.kind;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != cpnd_pkg::K_NUMBER) |-> m_tdata == '0)
    else $error("non-number item carries a nonzero step value");

  assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_end |=> state == '0)
    else $error("state not cleared after end item");

  assert property (@(posedge clk) disable iff (rst)
    state.just_got_number |-> state.partial_number == '0)
    else $error("number marked finished while partial number pending");

  assert property (@(posedge clk) disable iff (rst)
    (state.partial_number != '0) |-> state.saw_letter)
    else $error("partial number without any letter taken");

  assert property (@(posedge clk) disable iff (rst)
    s1_go && !s1_end && state.error_latched |-> !result.has_result)
    else $error("result produced after an error");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int CycleLimit = 200000;

  typedef struct {
    logic [7:0] letter;
    logic       last;
  } letter_item_t;

  typedef struct {
    cpnd_pkg::kind_t                kind;
    logic [cpnd_pkg::StepWidth-1:0] value;
  } step_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [3:0] m_tuser;

  letter_item_t letter_queue[$];
  step_result_t expected_steps[$];
  int sender_idle_pct = 31;
  int sink_idle_pct = 59;
  int mismatch_count = 0;
  int cycle_count = 0;

  // Decoder state as the stream has left it so far.
  logic [63:0] number_acc = '0;
  logic after_number = 1'b0;
  logic error_seen = 1'b0;
  logic letter_seen = 1'b0;
  logic unknown_seen = 1'b0;

  compressed_proof_number_decoder dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always #4 clk = ~clk;

  function automatic void decode_letter(input logic [7:0] ch, input logic fin,
                                        output logic hit, output step_result_t res);
    logic [63:0] lim;
    logic [63:0] wide;
    lim = {64{1'b1}} >> (64 - cpnd_pkg::NumberWidth);
    hit = 1'b1;
    res.kind = cpnd_pkg::K_NUMBER;
    res.value = '0;
    if (fin) begin
      hit = !error_seen;
      if (number_acc != 0) res.kind = cpnd_pkg::K_UNFINISHED;
      else if (!letter_seen) res.kind = cpnd_pkg::K_EMPTY;
      else if (unknown_seen) res.kind = cpnd_pkg::K_END_INCOMPLETE;
      else res.kind = cpnd_pkg::K_END_OK;
      number_acc = '0;
      after_number = 1'b0;
      error_seen = 1'b0;
      letter_seen = 1'b0;
      unknown_seen = 1'b0;
    end else if (error_seen) begin
      hit = 1'b0;
    end else if (ch == cpnd_pkg::ChrQuest) begin
      letter_seen = 1'b1;
      unknown_seen = 1'b1;
      after_number = 1'b0;
      if (number_acc != 0) begin
        res.kind = cpnd_pkg::K_UNFINISHED;
        error_seen = 1'b1;
      end else begin
        res.kind = cpnd_pkg::K_UNKNOWN;
      end
    end else if (ch < cpnd_pkg::ChrA || ch > cpnd_pkg::ChrZ) begin
      res.kind = cpnd_pkg::K_BAD_CHAR;
      error_seen = 1'b1;
    end else begin
      letter_seen = 1'b1;
      if (ch <= cpnd_pkg::ChrT) begin
        wide = number_acc * 20 + 64'(ch - cpnd_pkg::ChrA + 8'd1);
        if (wide > lim) begin
          res.kind = cpnd_pkg::K_OVERFLOW;
          error_seen = 1'b1;
        end else begin
          res.value = wide[cpnd_pkg::StepWidth-1:0];
          number_acc = '0;
          after_number = 1'b1;
        end
      end else if (ch <= cpnd_pkg::ChrY) begin
        wide = number_acc * 5 + 64'(ch - cpnd_pkg::ChrT);
        if (wide > lim) begin
          res.kind = cpnd_pkg::K_OVERFLOW;
          error_seen = 1'b1;
        end else begin
          number_acc = wide;
          after_number = 1'b0;
          hit = 1'b0;
        end
      end else if (!after_number) begin
        res.kind = cpnd_pkg::K_STRAY_Z;
        error_seen = 1'b1;
      end else begin
        after_number = 1'b0;
        res.kind = cpnd_pkg::K_ZERO;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (letter_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata <= letter_queue[0].letter;
        s_tlast <= letter_queue[0].last;
        void'(letter_queue.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    logic hit;
    step_result_t res;
    step_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        decode_letter(s_tdata, s_tlast, hit, res);
        if (hit) expected_steps.insert(expected_steps.size(), res);
      end
      if (m_tvalid && m_tready) begin
        if (expected_steps.size() == 0) begin
          $error("unexpected item: kind %0d, step_value %0d", m_tuser, m_tdata);
          mismatch_count++;
        end else begin
          want = expected_steps.pop_front();
          if (m_tuser !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, m_tuser);
            mismatch_count++;
          end
          if (m_tdata !== want.value) begin
            $error("step_value: expected %0d, got %0d", want.value, m_tdata);
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("compressed_proof_number_decoder verification failed");
      $finish;
    end
  end

  task automatic push_item(input logic [7:0] ch, input logic fin);
    letter_item_t it;
    it.letter = ch;
    it.last = fin;
    letter_queue.insert(letter_queue.size(), it);
  endtask

  task automatic push_proof(input string text);
    for (int i = 0; i < text.len(); i++) push_item(text[i], 1'b0);
    push_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic int high_digit_count();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(0, 2);
    if (r < 90) return $urandom_range(3, 8);
    return $urandom_range(9, 14);
  endfunction

  // Mostly well-formed proofs; about one in five is cut short, with a random, Z or high-digit letter at the cut.
  task automatic add_random_proof(inout int budget);
    int tokens;
    int cut;
    int r;
    int nhigh;
    tokens = ($urandom_range(99) < 3) ? 0 : $urandom_range(1, 10);
    cut = ($urandom_range(99) < 20) ? $urandom_range(0, tokens) : -1;
    for (int t = 0; t < tokens; t++) begin
      if (t == cut) break;
      if ($urandom_range(99) < 8) begin
        push_item(cpnd_pkg::ChrQuest, 1'b0);
        budget--;
      end else begin
        nhigh = high_digit_count();
        repeat (nhigh) push_item(cpnd_pkg::ChrT + 8'($urandom_range(1, 5)), 1'b0);
        push_item(cpnd_pkg::ChrA + 8'($urandom_range(0, 19)), 1'b0);
        budget -= nhigh + 1;
        if ($urandom_range(99) < 40) begin
          push_item(cpnd_pkg::ChrZ, 1'b0);
          budget--;
        end
      end
    end
    if (cut >= 0) begin
      r = $urandom_range(3);
      case (r)
        0: push_item(8'($urandom_range(0, 255)), 1'b0);
        1: push_item(cpnd_pkg::ChrZ, 1'b0);
        2: begin
          push_item(cpnd_pkg::ChrT + 8'($urandom_range(1, 5)), 1'b0);
          push_item(cpnd_pkg::ChrQuest, 1'b0);
          budget--;
        end
        default: push_item(cpnd_pkg::ChrT + 8'($urandom_range(1, 5)), 1'b0);
      endcase
      budget--;
      if (r != 3) repeat ($urandom_range(0, 3)) push_item(8'($urandom_range(0, 255)), 1'b0);
    end
    push_item(8'($urandom_range(0, 255)), 1'b1);
    budget--;
  endtask

  task automatic wait_drained();
    while (letter_queue.size() != 0 || s_tvalid || expected_steps.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(input int src_idle, input int sink_idle, input int count);
    int budget;
    budget = count;
    @(negedge clk);
    sender_idle_pct = src_idle;
    sink_idle_pct = sink_idle;
    while (budget > 0) add_random_proof(budget);
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    push_proof("");
    push_proof("UAYTZ");
    push_proof("?");
    push_proof("Z");
    push_item(8'h00, 1'b0);
    push_item(8'h00, 1'b1);
    push_proof("U");
    push_proof("U?");
    push_proof("YYYYYYYYYYYYTA");
    wait_drained();
    run_phase(31, 59, 530);
    run_phase(59, 31, 530);
    run_phase(0, 0, 540);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && expected_steps.size() == 0) begin
      $display("compressed_proof_number_decoder verification clean");
    end else begin
      $display("compressed_proof_number_decoder verification failed");
    end
    $finish;
  end

endmodule

@@ compressed_proof_number_decoder.f @@
rtl/cpnd_pkg.sv
rtl/cpnd_step.sv
rtl/compressed_proof_number_decoder.sv
test/testbench.sv
